[design/grs_pkg.sv]
package grs_pkg;

  // APB register file: one 32-bit register, word index taken from paddr[2]
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int GSIZE_W = 7;
  localparam logic REG_GRID_SIZE = 1'b0;
  localparam logic [GSIZE_W-1:0] GRID_SIZE_RST = 7'd64;

  // field widths fixed by the item format
  localparam int COORD_W = 6;

  // input word modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // neighbour order, pushed west first so that south is explored first
  localparam logic [1:0] NB_WEST  = 2'd0;
  localparam logic [1:0] NB_NORTH = 2'd1;
  localparam logic [1:0] NB_EAST  = 2'd2;
  localparam logic [1:0] NB_SOUTH = 2'd3;
  localparam logic [1:0] NB_LAST  = NB_SOUTH;

  typedef struct packed {
    logic       load_cell;    // write one open flag
    logic       start_query;  // latch query, clear result and stack
    logic       clr_step;     // clear one visited entry
    logic       issue_seed;   // read maps at the start cell
    logic       issue_nb;     // read maps at a neighbour of the popped cell
    logic [1:0] nb_sel;
    logic       eval;         // push the candidate if open and unvisited
    logic       pop;          // read stack top
    logic       hit;          // record target found
    logic       emit;         // load the output register
  } grs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic stack_empty;
    logic at_target;
    logic slot_free;
  } grs_status_t;

endpackage

[design/grs_ctrl.sv]
module grs_ctrl
  import grs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_mode,
  output logic        in_ready,
  input  grs_status_t status,
  output grs_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SEED  = 3'd2;
  localparam logic [2:0] S_SEVAL = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_POPD  = 3'd5;
  localparam logic [2:0] S_NB    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] nb_cnt_r, nb_cnt_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid & in_ready;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    nb_cnt_nxt = nb_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_mode == MODE_QUERY) begin
            cmd.start_query = 1'b1;
            state_nxt       = S_CLEAR;
          end else begin
            cmd.load_cell = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.issue_seed = 1'b1;
        state_nxt      = S_SEVAL;
      end
      S_SEVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (status.stack_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POPD;
        end
      end
      S_POPD: begin
        if (status.at_target) begin
          cmd.hit   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.issue_nb = 1'b1;
          cmd.nb_sel   = NB_WEST;
          nb_cnt_nxt   = NB_WEST;
          state_nxt    = S_NB;
        end
      end
      S_NB: begin
        // evaluate this neighbour while the next one is read
        cmd.eval = 1'b1;
        if (nb_cnt_r == NB_LAST) begin
          state_nxt = S_POP;
        end else begin
          cmd.issue_nb = 1'b1;
          cmd.nb_sel   = nb_cnt_r + 2'd1;
          nb_cnt_nxt   = nb_cnt_r + 2'd1;
        end
      end
      S_DONE: begin
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      nb_cnt_r <= NB_WEST;
    end else begin
      state_r  <= state_nxt;
      nb_cnt_r <= nb_cnt_nxt;
    end
  end

endmodule

[design/grs_dpath.sv]
module grs_dpath
  import grs_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  grs_cmd_t           cmd,
  output grs_status_t        status,
  input  logic [COORD_W-1:0] in_cell_row,
  input  logic [COORD_W-1:0] in_cell_col,
  input  logic               in_cell_open,
  input  logic [COORD_W-1:0] in_start_row,
  input  logic [COORD_W-1:0] in_start_col,
  input  logic [COORD_W-1:0] in_end_row,
  input  logic [COORD_W-1:0] in_end_col,
  input  logic               cfg_we,
  input  logic [GSIZE_W-1:0] cfg_wdata,
  output logic [GSIZE_W-1:0] grid_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_reachable
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 2 ** AW;
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int DW    = AW + 1;
  localparam int KW    = (CW + 1 > GSIZE_W) ? CW + 1 : GSIZE_W;

  logic [GSIZE_W-1:0] grid_size_r;
  logic [KW-1:0]      side;

  logic [AW-1:0] start_addr_r, tgt_r;
  logic          inb_r;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [DW-1:0] depth_r, depth_nxt, depth_m1;
  logic          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_reachable_r;

  logic [AW-1:0] cand_addr_r;
  logic          cand_ok_r;
  logic          open_q_r, vis_q_r;
  logic [AW-1:0] stk_q_r;

  logic [CW-1:0] cur_row, cur_col;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;
  logic          load_ok, query_ok, push;
  logic          vis_we, vis_wd;
  logic [AW-1:0] vis_wa;

  logic          open_mem [DEPTH];
  logic          vis_mem  [DEPTH];
  logic [AW-1:0] stk_mem  [DEPTH];

  assign grid_size = grid_size_r;
  assign side = (KW'(grid_size_r) > KW'(MAX_DIM)) ? KW'(MAX_DIM) : KW'(grid_size_r);

  assign load_ok  = (KW'(in_cell_row) < KW'(MAX_DIM)) && (KW'(in_cell_col) < KW'(MAX_DIM));
  assign query_ok = (KW'(in_start_row) < side) && (KW'(in_start_col) < side) &&
                    (KW'(in_end_row) < side) && (KW'(in_end_col) < side);

  assign cur_row = stk_q_r[AW-1:CW];
  assign cur_col = stk_q_r[CW-1:0];

  // address of the cell read this cycle and whether it lies inside the grid
  always_comb begin
    rd_addr = start_addr_r;
    rd_ok   = inb_r;
    if (cmd.issue_nb) begin
      case (cmd.nb_sel)
        NB_WEST: begin
          rd_addr = {cur_row, cur_col - CW'(1)};
          rd_ok   = (cur_col != '0);
        end
        NB_NORTH: begin
          rd_addr = {cur_row - CW'(1), cur_col};
          rd_ok   = (cur_row != '0);
        end
        NB_EAST: begin
          rd_addr = {cur_row, cur_col + CW'(1)};
          rd_ok   = ((KW'(cur_col) + KW'(1)) < side);
        end
        NB_SOUTH: begin
          rd_addr = {cur_row + CW'(1), cur_col};
          rd_ok   = ((KW'(cur_row) + KW'(1)) < side);
        end
        default: begin
          rd_addr = start_addr_r;
          rd_ok   = 1'b0;
        end
      endcase
    end
  end

  assign push = cmd.eval & cand_ok_r & open_q_r & ~vis_q_r & (depth_r < DW'(CELLS));
  assign depth_m1 = depth_r - DW'(1);

  // one write port on the visited map: clear sweep or mark on push
  assign vis_we = cmd.clr_step | push;
  assign vis_wa = cmd.clr_step ? clr_cnt_r : cand_addr_r;
  assign vis_wd = ~cmd.clr_step;

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    depth_nxt     = depth_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (cmd.start_query) begin
      clr_cnt_nxt = '0;
      depth_nxt   = '0;
      res_nxt     = 1'b0;
    end
    if (cmd.clr_step) clr_cnt_nxt = clr_cnt_r + AW'(1);
    if (push)         depth_nxt   = depth_r + DW'(1);
    if (cmd.pop)      depth_nxt   = depth_m1;
    if (cmd.hit)      res_nxt     = 1'b1;
    if (cmd.emit)           out_valid_nxt = 1'b1;
    else if (out_ready)     out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_SIZE_RST;
      clr_cnt_r   <= '0;
      depth_r     <= '0;
      res_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) grid_size_r <= cfg_wdata;
      clr_cnt_r   <= clr_cnt_nxt;
      depth_r     <= depth_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      start_addr_r <= {CW'(in_start_row), CW'(in_start_col)};
      tgt_r        <= {CW'(in_end_row), CW'(in_end_col)};
      inb_r        <= query_ok;
    end
    if (cmd.issue_seed | cmd.issue_nb) begin
      cand_addr_r <= rd_addr;
      cand_ok_r   <= rd_ok;
    end
    if (cmd.emit) out_reachable_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cell && load_ok) open_mem[{CW'(in_cell_row), CW'(in_cell_col)}] <= in_cell_open;
    open_q_r <= open_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q_r <= vis_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (push) stk_mem[depth_r[AW-1:0]] <= cand_addr_r;
    if (cmd.pop) stk_q_r <= stk_mem[depth_m1[AW-1:0]];
  end

  assign status.clr_last    = (clr_cnt_r == {AW{1'b1}});
  assign status.stack_empty = (depth_r == '0);
  assign status.at_target   = (stk_q_r == tgt_r);
  assign status.slot_free   = ~out_valid_r | out_ready;

  assign out_valid     = out_valid_r;
  assign out_reachable = out_reachable_r;

endmodule

[design/grid_reachability_search.sv]
// Grid reachability search: does an open path join two cells of a square grid?
// Input channel (in_valid/in_ready): each word is either a load (in_mode = 0),
// which writes the open flag of one cell, or a query (in_mode = 1), which
// carries start and end coordinates. Loads give no result; each query gives
// one word on the result channel (out_valid/out_ready) carrying out_reachable.
// APB port: one register, grid_size at byte address 0, side of the grid in use.
// Loads may follow each other in every cycle while no query is in progress.
// A query first sweeps the visited map, one entry a cycle, all 2**(2*clog2(MAX_DIM))
// entries (4096 at MAX_DIM = 64). The walk then evaluates the start cell and,
// for each cell taken from the stack, pops it, reads the stack and makes four
// neighbour reads overlapped with the pushes; for the cell found to be the target
// only the pop and stack read are done. Finishing hands the result to the output
// register, after an empty-stack check on a miss.
// The result sits in an output register: the next word is taken while it
// waits, and a later query holds in its final state until the receiver has
// taken the earlier result.
// Reset (synchronous, active low) returns to idle, empties the result
// register and sets grid_size to 64. The open map is not cleared by reset.
module grid_reachability_search
  import grs_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [COORD_W-1:0] in_cell_row,
  input  logic [COORD_W-1:0] in_cell_col,
  input  logic               in_cell_open,
  input  logic [COORD_W-1:0] in_start_row,
  input  logic [COORD_W-1:0] in_start_col,
  input  logic [COORD_W-1:0] in_end_row,
  input  logic [COORD_W-1:0] in_end_col,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_reachable,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  grs_cmd_t           cmd;
  grs_status_t        status;
  logic               cfg_we;
  logic [GSIZE_W-1:0] grid_size;

  // Registers are 32-bit words; paddr[2] picks the word, higher words are empty.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_GRID_SIZE);
  assign prdata = (paddr[2] == REG_GRID_SIZE) ? PDATA_W'(grid_size) : '0;

  // Sequencer: walks idle, clear sweep, seed, pop, neighbour and done steps.
  grs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: open map, visited map, walk stack and the result register.
  grs_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_cell_row   (in_cell_row),
    .in_cell_col   (in_cell_col),
    .in_cell_open  (in_cell_open),
    .in_start_row  (in_start_row),
    .in_start_col  (in_start_col),
    .in_end_row    (in_end_row),
    .in_end_col    (in_end_col),
    .cfg_we        (cfg_we),
    .cfg_wdata     (pwdata[GSIZE_W-1:0]),
    .grid_size     (grid_size),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_reachable (out_reachable)
  );

endmodule

[design/grs_checker.sv]
module grs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic out_reachable
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reachable))
    else $error("result word dropped or changed while stalled");

  // a query is never followed at once by another accepted word
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("input taken straight after a query");

  // a load leaves the input channel ready for the next word
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> in_ready)
    else $error("load stalled the input channel");

  // a new result only appears as a query finishes
  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word raised while idle");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind grid_reachability_search grs_checker u_grs_checker (.*);
